@@ design/rst_pkg.sv @@
// ----------------------------------------------------------------------------
// rst_pkg: shared types and constants for the session table
// Opcodes, status codes, sequencer states and table sizes.
// ----------------------------------------------------------------------------
package rst_pkg;
    localparam int SLOTS = 64;
    localparam int REF_BITS = 16;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int ENT_W = 64 + 64 + REF_BITS + 32 + 32;

    localparam logic [2:0] OP_REGISTER = 3'd0;
    localparam logic [2:0] OP_UNREGISTER = 3'd1;
    localparam logic [2:0] OP_ACQUIRE = 3'd2;
    localparam logic [2:0] OP_RELEASE = 3'd3;
    localparam logic [2:0] OP_GET = 3'd4;
    localparam logic [2:0] OP_EXISTS = 3'd5;
    localparam logic [2:0] OP_STATS = 3'd6;
    localparam logic [2:0] OP_CLEANUP = 3'd7;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_EXISTS = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_FINISH,
        S_OUT
    } t_state;
endpackage

@@ design/refcounted_session_table.sv @@
// ----------------------------------------------------------------------------
// refcounted_session_table: reference-counted session table
// Sixty-four session slots with lookup, refcounting, stats and idle cleanup.
// ----------------------------------------------------------------------------
// One operation at a time. Every op except an invalid-argument reject sweeps
// the slot RAM one entry a cycle (read issued, data back next cycle). Register
// writes a free slot and acquire, release and get write the matched slot, once
// after the sweep; unregister and cleanup only clear valid bits, cleanup doing
// so during the sweep. A reject skips the sweep and goes straight to the
// result. Valid bits sit in flip-flops cleared by reset, so no clearing pass is
// needed. The result is held in an output register until taken; the next beat
// is accepted once it is gone.
module refcounted_session_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_op,
    input  logic [63:0] i_session_key,
    input  logic [63:0] i_params_handle,
    input  logic [31:0] i_now_seconds,
    input  logic [30:0] i_max_idle,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [63:0] o_found_handle,
    output logic        o_present,
    output logic [6:0]  o_active_count,
    output logic [22:0] o_total_refs,
    output logic [31:0] o_oldest_age,
    output logic [6:0]  o_cleaned_count
);
    localparam int IW = rst_pkg::IDX_W;
    localparam int RB = rst_pkg::REF_BITS;
    localparam int EW = rst_pkg::ENT_W;

    rst_pkg::t_state r_state, n_state;

    logic [rst_pkg::SLOTS-1:0] r_vld;
    logic [2:0]  r_op;
    logic [63:0] r_key, r_hnd;
    logic [31:0] r_now;
    logic [30:0] r_lim;
    logic [IW-1:0] r_idx;     // address being read
    logic [IW-1:0] r_cidx;    // address whose data is in rdata
    logic        r_last;      // rdata belongs to the last slot
    logic        r_hit, r_free_ok;
    logic [IW-1:0] r_hit_idx, r_free_idx;
    logic [EW-1:0] r_hit_ent;
    logic [6:0]  r_act, r_cln;
    logic [22:0] r_tot;
    logic [31:0] r_old;

    logic          we;
    logic [IW-1:0] addr;
    logic [EW-1:0] wdata, rdata;

    rst_ram #(.WIDTH(EW), .DEPTH(rst_pkg::SLOTS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (addr),
        .i_wdata(wdata),
        .o_rdata(rdata)
    );

    // entry layout: key | handle | refs | created | last access
    logic [63:0] e_key, e_hnd;
    logic [RB-1:0] e_refs;
    logic [31:0] e_crt, e_acc;
    assign {e_key, e_hnd, e_refs, e_crt, e_acc} = rdata;

    logic [63:0] h_key, h_hnd;
    logic [RB-1:0] h_refs;
    logic [31:0] h_crt, h_acc;
    assign {h_key, h_hnd, h_refs, h_crt, h_acc} = r_hit_ent;

    logic c_v, c_match, c_stale, reject;
    logic [31:0] age, idle;
    logic [23:0] sum;
    assign c_v = r_vld[r_cidx];
    assign c_match = c_v && (e_key == r_key);
    assign age = r_now - e_crt;
    assign idle = r_now - e_acc;
    assign c_stale = c_v && (e_refs == '0) && (idle > {1'b0, r_lim}) && (r_lim != '0);
    assign sum = {1'b0, r_tot} + 24'(e_refs);
    assign reject = (i_op <= rst_pkg::OP_EXISTS) && ((i_session_key == '0) ||
                    ((i_op == rst_pkg::OP_REGISTER) && (i_params_handle == '0)));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rst_pkg::S_IDLE:   if (i_valid) n_state = reject ? rst_pkg::S_OUT : rst_pkg::S_READ;
            rst_pkg::S_READ:   n_state = rst_pkg::S_SCAN;
            rst_pkg::S_SCAN: begin
                if (r_last) n_state = rst_pkg::S_FINISH;
                else n_state = rst_pkg::S_SCAN;
            end
            rst_pkg::S_FINISH: n_state = rst_pkg::S_OUT;
            rst_pkg::S_OUT:    if (i_ready) n_state = rst_pkg::S_IDLE;
            default:           n_state = rst_pkg::S_IDLE;
        endcase
    end

    // outputs to the RAM and handshake
    logic [RB-1:0] nref;
    always_comb begin
        we = 1'b0;
        addr = r_idx;
        wdata = r_hit_ent;
        nref = h_refs;
        case (r_op)
            rst_pkg::OP_ACQUIRE: if (h_refs != '1) nref = h_refs + 1'b1;
            rst_pkg::OP_RELEASE: if (h_refs != '0) nref = h_refs - 1'b1;
            default: nref = h_refs;
        endcase
        case (r_state)
            rst_pkg::S_SCAN: addr = r_idx;
            rst_pkg::S_FINISH: begin
                if (r_op == rst_pkg::OP_REGISTER) begin
                    addr = r_free_idx;
                    we = !r_hit && r_free_ok;
                    wdata = {r_key, r_hnd, RB'(1), r_now, r_now};
                end else begin
                    addr = r_hit_idx;
                    we = r_hit && (r_op == rst_pkg::OP_ACQUIRE ||
                         r_op == rst_pkg::OP_RELEASE || r_op == rst_pkg::OP_GET);
                    wdata = {h_key, h_hnd, nref, h_crt,
                             (r_op == rst_pkg::OP_RELEASE) ? h_acc : r_now};
                end
            end
            default: addr = r_idx;
        endcase
    end
    assign o_ready = (r_state == rst_pkg::S_IDLE);
    assign o_valid = (r_state == rst_pkg::S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rst_pkg::S_IDLE;
            r_vld <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                rst_pkg::S_IDLE: begin
                    r_op <= i_op; r_key <= i_session_key; r_hnd <= i_params_handle;
                    r_now <= i_now_seconds; r_lim <= i_max_idle;
                    r_idx <= '0; r_hit <= 1'b0; r_free_ok <= 1'b0;
                    r_act <= '0; r_tot <= '0; r_old <= '0; r_cln <= '0;
                    o_status <= reject ? rst_pkg::ST_INVALID : rst_pkg::ST_OK;
                    o_found_handle <= '0; o_present <= 1'b0; o_active_count <= '0;
                    o_total_refs <= '0; o_oldest_age <= '0; o_cleaned_count <= '0;
                end
                rst_pkg::S_READ, rst_pkg::S_SCAN: begin
                    if (r_state == rst_pkg::S_SCAN) begin
                        if (c_match && !r_hit) begin
                            r_hit <= 1'b1; r_hit_idx <= r_cidx; r_hit_ent <= rdata;
                        end
                        if (!c_v && !r_free_ok) begin
                            r_free_ok <= 1'b1; r_free_idx <= r_cidx;
                        end
                        if (c_v) begin
                            if (r_act != 7'h7F) r_act <= r_act + 7'd1;
                            r_tot <= sum[23] ? 23'h7FFFFF : sum[22:0];
                            if (age > r_old) r_old <= age;
                        end
                        if (r_op == rst_pkg::OP_CLEANUP && c_stale) begin
                            r_vld[r_cidx] <= 1'b0;
                            if (r_cln != 7'h7F) r_cln <= r_cln + 7'd1;
                        end
                    end
                    r_cidx <= r_idx;
                    r_last <= (r_idx == IW'(rst_pkg::SLOTS - 1));
                    if (r_idx != IW'(rst_pkg::SLOTS - 1)) r_idx <= r_idx + 1'b1;
                end
                rst_pkg::S_FINISH: begin
                    if (r_op == rst_pkg::OP_REGISTER) begin
                        if (r_hit) o_status <= rst_pkg::ST_EXISTS;
                        else if (!r_free_ok) o_status <= rst_pkg::ST_FULL;
                        else r_vld[r_free_idx] <= 1'b1;
                    end else if (r_op <= rst_pkg::OP_EXISTS) begin
                        if (!r_hit) o_status <= rst_pkg::ST_NOT_FOUND;
                        else begin
                            if (r_op == rst_pkg::OP_UNREGISTER) r_vld[r_hit_idx] <= 1'b0;
                            if (r_op == rst_pkg::OP_GET) o_found_handle <= h_hnd;
                            if (r_op == rst_pkg::OP_EXISTS) o_present <= 1'b1;
                        end
                    end else if (r_op == rst_pkg::OP_STATS) begin
                        o_active_count <= r_act; o_total_refs <= r_tot;
                        o_oldest_age <= r_old;
                    end else begin
                        o_cleaned_count <= r_cln;
                    end
                end
                default: ;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && !o_ready))
        else $error("result dropped while stalled");
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("ready while result pending");
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found_handle != '0) |-> (o_status == rst_pkg::ST_OK))
        else $error("handle with error status");
endmodule

@@ design/rst_ram.sv @@
// ----------------------------------------------------------------------------
// rst_ram: generic single-port RAM
// One write and one read of the same address per cycle, registered read data.
// ----------------------------------------------------------------------------
module rst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
